### rtl/i2c_master_transaction_sequencer_unit_macros.svh
// assertion macros shared by the sequencer checker
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH

// concurrent check, masked while reset is asserted
`define I2C_MTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// concurrent check that also runs through reset
`define I2C_MTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/i2c_mts_pkg.sv
// shared types and codes of the i2c master transaction sequencer
`default_nettype none

package i2c_mts_pkg;

    // operations of the request channel
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    // bus controller status codes
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NAK = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK = 8'h28;
    localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
    localparam logic [7:0] ST_ADDR_R_NAK = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK = 8'h50;
    localparam logic [7:0] ST_DATA_R_NAK = 8'h58;

    // transfer modes
    localparam logic [1:0] MODE_WRITE      = 2'd0;
    localparam logic [1:0] MODE_READ       = 2'd1;
    localparam logic [1:0] MODE_WRITE_READ = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_TRANSFER_MODE = 2'd1;
    localparam logic [1:0] REG_TX_COUNT      = 2'd2;
    localparam logic [1:0] REG_RX_COUNT      = 2'd3;

    localparam logic [4:0] POS_MAX = 5'd31;

    typedef struct packed {
        logic [6:0] slave_address;
        logic [1:0] transfer_mode;
        logic [4:0] tx_count;
        logic [4:0] rx_count;
    } cfg_t;

    // where the outgoing byte comes from
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_ADDR = 2'd1,
        SRC_BUF  = 2'd2
    } send_src_t;

    typedef struct packed {
        send_src_t  src;
        logic [7:0] addr_byte;
        logic       buf_ok;
        logic       request_start;
        logic       clear_start;
        logic       request_stop;
        logic       store_valid;
        logic [3:0] store_index;
        logic [7:0] store_value;
        logic       done;
    } result_t;

endpackage

`default_nettype wire

### rtl/i2c_mts_cfg.sv
// apb register file holding address, mode and byte counts
`default_nettype none

module i2c_mts_cfg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output i2c_mts_pkg::cfg_t       cfg
);

    i2c_mts_pkg::cfg_t cfg_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (paddr[3:2])
                i2c_mts_pkg::REG_SLAVE_ADDRESS: cfg_reg.slave_address <= pwdata[6:0];
                i2c_mts_pkg::REG_TRANSFER_MODE: cfg_reg.transfer_mode <= pwdata[1:0];
                i2c_mts_pkg::REG_TX_COUNT:      cfg_reg.tx_count      <= pwdata[4:0];
                i2c_mts_pkg::REG_RX_COUNT:      cfg_reg.rx_count      <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[3:2])
            i2c_mts_pkg::REG_SLAVE_ADDRESS: prdata = {25'd0, cfg_reg.slave_address};
            i2c_mts_pkg::REG_TRANSFER_MODE: prdata = {30'd0, cfg_reg.transfer_mode};
            i2c_mts_pkg::REG_TX_COUNT:      prdata = {27'd0, cfg_reg.tx_count};
            i2c_mts_pkg::REG_RX_COUNT:      prdata = {27'd0, cfg_reg.rx_count};
            default:                        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/i2c_mts_txbuf.sv
// transmit buffer memory, one write and one registered read port
`default_nettype none

module i2c_mts_txbuf #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic       aclk,
    input  wire logic       wr_en,
    input  wire logic [3:0] wr_idx,
    input  wire logic [7:0] wr_data,
    input  wire logic       rd_en,
    input  wire logic [4:0] rd_idx,
    output logic      [7:0] rd_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [7:0] mem_reg [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;
    logic [8:0] wr_wide;
    logic [8:0] rd_wide;
    logic       wr_ok;
    logic       rd_ok;

    assign wr_wide = {5'd0, wr_idx};
    assign rd_wide = {4'd0, rd_idx};
    assign wr_ok   = {28'd0, wr_idx} < 32'(BUFFER_DEPTH);
    assign rd_ok   = {27'd0, rd_idx} < 32'(BUFFER_DEPTH);
    assign rd_data = rd_data_reg;

    // slots beyond the depth are neither written nor read
    always_ff @(posedge aclk) begin
        if (wr_en && wr_ok) begin
            mem_reg[wr_wide[AW-1:0]] <= wr_data;
        end
        if (rd_en && rd_ok) begin
            rd_data_reg <= mem_reg[rd_wide[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

### rtl/i2c_mts_ctrl.sv
// event decode, sequencer state and result register
`default_nettype none

module i2c_mts_ctrl #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire i2c_mts_pkg::cfg_t     cfg,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_operation,
    input  wire logic [7:0]            s_status_code,
    input  wire logic [7:0]            s_received_byte,
    input  wire logic                  m_ready,
    output logic                       accept,
    output logic      [4:0]            rd_pos,
    output logic                       res_valid,
    output i2c_mts_pkg::result_t       res
);

    logic [4:0]           pos_reg, pos_next;
    logic [1:0]           mode_reg, mode_next;
    logic                 fin_reg, fin_next;
    logic                 res_valid_reg, res_valid_next;
    i2c_mts_pkg::result_t res_reg, res_next;
    logic [4:0]           pos_adv;
    logic                 pos_ok;
    logic                 do_store;

    assign s_ready   = !res_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign rd_pos    = pos_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign pos_adv = (pos_reg < i2c_mts_pkg::POS_MAX) ? pos_reg + 5'd1 : pos_reg;
    assign pos_ok  = {27'd0, pos_reg} < 32'(BUFFER_DEPTH);

    // decode one request against the current state
    always_comb begin
        pos_next  = pos_reg;
        mode_next = mode_reg;
        fin_next  = fin_reg;
        do_store  = 1'b0;
        res_next  = '0;
        res_next.src       = i2c_mts_pkg::SRC_NONE;
        res_next.addr_byte = {cfg.slave_address, mode_reg == i2c_mts_pkg::MODE_READ};
        res_next.buf_ok    = pos_ok;
        case (s_operation)
            i2c_mts_pkg::OP_START: begin
                pos_next  = '0;
                mode_next = cfg.transfer_mode;
                fin_next  = 1'b0;
                res_next.request_start = 1'b1;
            end
            i2c_mts_pkg::OP_STATUS: begin
                case (s_status_code)
                    i2c_mts_pkg::ST_START, i2c_mts_pkg::ST_RESTART: begin
                        res_next.src         = i2c_mts_pkg::SRC_ADDR;
                        res_next.clear_start = 1'b1;
                    end
                    i2c_mts_pkg::ST_ADDR_W_ACK: begin
                        res_next.src = i2c_mts_pkg::SRC_BUF;
                        pos_next     = pos_adv;
                    end
                    i2c_mts_pkg::ST_ADDR_W_NAK: begin
                        res_next.src = i2c_mts_pkg::SRC_ADDR;
                    end
                    i2c_mts_pkg::ST_ADDR_R_NAK: begin
                        res_next.request_stop = 1'b1;
                        fin_next              = 1'b1;
                    end
                    i2c_mts_pkg::ST_DATA_W_ACK: begin
                        if (pos_reg < cfg.tx_count) begin
                            res_next.src = i2c_mts_pkg::SRC_BUF;
                            pos_next     = pos_adv;
                        end else if (mode_reg == i2c_mts_pkg::MODE_WRITE) begin
                            res_next.request_stop = 1'b1;
                            fin_next              = 1'b1;
                        end else if (mode_reg == i2c_mts_pkg::MODE_WRITE_READ) begin
                            mode_next              = i2c_mts_pkg::MODE_READ;
                            pos_next               = '0;
                            res_next.request_start = 1'b1;
                        end
                    end
                    i2c_mts_pkg::ST_DATA_R_ACK: begin
                        if (pos_reg < cfg.rx_count) begin
                            do_store = 1'b1;
                        end else begin
                            res_next.request_stop = 1'b1;
                            fin_next              = 1'b1;
                        end
                    end
                    i2c_mts_pkg::ST_DATA_R_NAK: begin
                        do_store              = 1'b1;
                        res_next.request_stop = 1'b1;
                        fin_next              = 1'b1;
                    end
                    default: ;
                endcase
                // received byte store, suppressed past the buffer end
                if (do_store) begin
                    pos_next = pos_adv;
                    if (pos_ok) begin
                        res_next.store_valid = 1'b1;
                        res_next.store_index = pos_reg[3:0];
                        res_next.store_value = s_received_byte;
                    end
                end
            end
            default: ;
        endcase
        res_next.done = fin_next;
    end

    // output register handshake
    always_comb begin
        if (accept) begin
            res_valid_next = 1'b1;
        end else if (m_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            mode_reg      <= '0;
            fin_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (accept) begin
                pos_reg  <= pos_next;
                mode_reg <= mode_next;
                fin_reg  <= fin_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

### rtl/i2c_master_transaction_sequencer_unit.sv
// Top level of the i2c master transaction sequencer.
// Requests on the s_ channel carry one event each: load a transmit byte
// into a buffer slot, start a transaction, or a bus status event with the
// controller status code and the byte read from the bus. Every request
// gives exactly one result on the m_ channel: the byte to send, start,
// clear-start and stop requests, a received-byte store and the done flag.
// Slave address, transfer mode and byte counts are set over the apb port;
// the user must set them only while the block is idle, which the block
// itself does not enforce; pready is always high. The result of a request
// accepted at an edge is on the m_ channel in the cycle after that edge,
// from the result register and the transmit buffer read port.
// Throughput is one request per cycle while the m_ channel is not stalled,
// with the single read and single write port of the transmit buffer memory
// and the position, mode and done registers updated on each accepted request.
// When the receiver stalls the result holds in its register and s_ready
// stays high only if m_ready is high, so no result is lost.
// Synchronous reset clears position, mode, done flag, the registers and the
// result valid; the transmit buffer is not cleared and must be loaded
// before it is read.
`default_nettype none

module i2c_master_transaction_sequencer_unit #(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [7:0]  s_status_code,
    input  wire logic [7:0]  s_received_byte,
    input  wire logic [3:0]  s_load_index,
    input  wire logic [7:0]  s_load_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_send_valid,
    output logic      [7:0]  m_send_byte,
    output logic             m_request_start,
    output logic             m_clear_start,
    output logic             m_request_stop,
    output logic             m_store_valid,
    output logic      [3:0]  m_store_index,
    output logic      [7:0]  m_store_value,
    output logic             m_done_res
);

    i2c_mts_pkg::cfg_t    cfg;
    i2c_mts_pkg::result_t res;
    logic                 accept;
    logic [4:0]           rd_pos;
    logic [7:0]           rd_data;

    i2c_mts_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2c_mts_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_status_code   (s_status_code),
        .s_received_byte (s_received_byte),
        .m_ready         (m_ready),
        .accept          (accept),
        .rd_pos          (rd_pos),
        .res_valid       (m_valid),
        .res             (res)
    );

    // loads write, every accepted request reads the current position
    i2c_mts_txbuf #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_txbuf (
        .aclk    (aclk),
        .wr_en   (accept && (s_operation == i2c_mts_pkg::OP_LOAD)),
        .wr_idx  (s_load_index),
        .wr_data (s_load_value),
        .rd_en   (accept),
        .rd_idx  (rd_pos),
        .rd_data (rd_data)
    );

    // outgoing byte select
    always_comb begin
        case (res.src)
            i2c_mts_pkg::SRC_ADDR: begin
                m_send_valid = 1'b1;
                m_send_byte  = res.addr_byte;
            end
            i2c_mts_pkg::SRC_BUF: begin
                m_send_valid = 1'b1;
                m_send_byte  = res.buf_ok ? rd_data : 8'd0;
            end
            default: begin
                m_send_valid = 1'b0;
                m_send_byte  = 8'd0;
            end
        endcase
    end

    assign m_request_start = res.request_start;
    assign m_clear_start   = res.clear_start;
    assign m_request_stop  = res.request_stop;
    assign m_store_valid   = res.store_valid;
    assign m_store_index   = res.store_index;
    assign m_store_value   = res.store_value;
    assign m_done_res      = res.done;

endmodule

`default_nettype wire

### rtl/i2c_mts_checker.sv
// port-level checks on the sequencer and their bind
`default_nettype none
`include "i2c_master_transaction_sequencer_unit_macros.svh"

module i2c_mts_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [1:0] s_operation,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_send_valid,
    input wire logic [7:0] m_send_byte,
    input wire logic       m_request_start,
    input wire logic       m_request_stop,
    input wire logic       m_done_res
);

    logic start_acc;
    logic start_res;
    logic res_stall;

    // accepted start request and the result it must give
    assign start_acc = s_valid && s_ready && (s_operation == i2c_mts_pkg::OP_START);
    assign start_res = m_valid && m_request_start && !m_done_res;
    assign res_stall = m_valid && !m_ready;

    `I2C_MTS_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")
    `I2C_MTS_ASSERT(a_stall_holds, res_stall |=> m_valid && $stable(m_send_byte), "stall moved")
    `I2C_MTS_ASSERT(a_start_result, start_acc |=> start_res, "start request without start result")
    `I2C_MTS_ASSERT(a_idle_byte, m_valid && !m_send_valid |-> m_send_byte == 8'd0, "stray byte")
    `I2C_MTS_ASSERT(a_stop_done, m_valid && m_request_stop |-> m_done_res, "stop without done")

endmodule

bind i2c_master_transaction_sequencer_unit i2c_mts_checker u_chk (.*);

`default_nettype wire

### sim/i2c_mts_sequence_checker.sv
// request/result checker for the i2c master transaction sequencer
module i2c_mts_sequence_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_status_code,
    input  logic [7:0]  s_received_byte,
    input  logic [3:0]  s_load_index,
    input  logic [7:0]  s_load_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_send_valid,
    input  logic [7:0]  m_send_byte,
    input  logic        m_request_start,
    input  logic        m_clear_start,
    input  logic        m_request_stop,
    input  logic        m_store_valid,
    input  logic [3:0]  m_store_index,
    input  logic [7:0]  m_store_value,
    input  logic        m_done_res,
    output int          outstanding,
    output int          failures
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TX_DEPTH = 16;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] status_code;
        logic [7:0] received_byte;
        logic [3:0] load_index;
        logic [7:0] load_value;
    } bus_event_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       request_start;
        logic       clear_start;
        logic       request_stop;
        logic       store_valid;
        logic [3:0] store_index;
        logic [7:0] store_value;
        logic       done;
    } bus_outcome_t;

    // mirrored registers and sequencer state
    i2c_mts_pkg::cfg_t regs;
    logic [7:0]        tx_shadow [TX_DEPTH];
    logic [4:0]        position;
    logic [1:0]        active_mode;
    logic              finished;
    bus_outcome_t      pending_outcomes [$];
    bus_event_t        accepted;
    bus_outcome_t      seen;
    bus_outcome_t      wanted;

    function automatic logic [7:0] address_byte();
        return {regs.slave_address, active_mode == i2c_mts_pkg::MODE_READ};
    endfunction

    function automatic logic [7:0] tx_byte_at(input logic [4:0] pos);
        if (pos < TX_DEPTH) begin
            return tx_shadow[pos[3:0]];
        end
        return 8'h00;
    endfunction

    // position saturates at the top of its range
    function automatic void step_position();
        if (position != i2c_mts_pkg::POS_MAX) begin
            position = position + 5'd1;
        end
    endfunction

    // next state and the result that one request gives
    function automatic bus_outcome_t predict_outcome(input bus_event_t ev);
        bus_outcome_t r;
        logic         take_byte;
        r = '0;
        take_byte = 1'b0;
        case (ev.operation)
            i2c_mts_pkg::OP_LOAD: begin
                tx_shadow[ev.load_index] = ev.load_value;
            end
            i2c_mts_pkg::OP_START: begin
                position = '0;
                active_mode = regs.transfer_mode;
                finished = 1'b0;
                r.request_start = 1'b1;
            end
            i2c_mts_pkg::OP_STATUS: begin
                case (ev.status_code)
                    i2c_mts_pkg::ST_START, i2c_mts_pkg::ST_RESTART: begin
                        r.send_valid = 1'b1;
                        r.send_byte = address_byte();
                        r.clear_start = 1'b1;
                    end
                    i2c_mts_pkg::ST_ADDR_W_ACK: begin
                        r.send_valid = 1'b1;
                        r.send_byte = tx_byte_at(position);
                        step_position();
                    end
                    i2c_mts_pkg::ST_ADDR_W_NAK: begin
                        r.send_valid = 1'b1;
                        r.send_byte = address_byte();
                    end
                    i2c_mts_pkg::ST_ADDR_R_ACK: begin
                    end
                    i2c_mts_pkg::ST_ADDR_R_NAK: begin
                        r.request_stop = 1'b1;
                        finished = 1'b1;
                    end
                    i2c_mts_pkg::ST_DATA_W_ACK: begin
                        if (position < regs.tx_count) begin
                            r.send_valid = 1'b1;
                            r.send_byte = tx_byte_at(position);
                            step_position();
                        end else if (active_mode == i2c_mts_pkg::MODE_WRITE) begin
                            r.request_stop = 1'b1;
                            finished = 1'b1;
                        end else if (active_mode == i2c_mts_pkg::MODE_WRITE_READ) begin
                            active_mode = i2c_mts_pkg::MODE_READ;
                            position = '0;
                            r.request_start = 1'b1;
                        end
                    end
                    i2c_mts_pkg::ST_DATA_R_ACK: begin
                        if (position < regs.rx_count) begin
                            take_byte = 1'b1;
                        end else begin
                            r.request_stop = 1'b1;
                            finished = 1'b1;
                        end
                    end
                    i2c_mts_pkg::ST_DATA_R_NAK: begin
                        take_byte = 1'b1;
                        r.request_stop = 1'b1;
                        finished = 1'b1;
                    end
                    default: begin
                    end
                endcase
                // stores past the end of the receive buffer are dropped
                if (take_byte) begin
                    if (position < TX_DEPTH) begin
                        r.store_valid = 1'b1;
                        r.store_index = position[3:0];
                        r.store_value = ev.received_byte;
                    end
                    step_position();
                end
            end
            default: begin
            end
        endcase
        r.done = finished;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs = '0;
            position = '0;
            active_mode = i2c_mts_pkg::MODE_WRITE;
            finished = 1'b0;
            pending_outcomes.delete();
        end else begin
            // register writes on the configuration port
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    i2c_mts_pkg::REG_SLAVE_ADDRESS: regs.slave_address = pwdata[6:0];
                    i2c_mts_pkg::REG_TRANSFER_MODE: regs.transfer_mode = pwdata[1:0];
                    i2c_mts_pkg::REG_TX_COUNT:      regs.tx_count = pwdata[4:0];
                    i2c_mts_pkg::REG_RX_COUNT:      regs.rx_count = pwdata[4:0];
                    default: begin
                    end
                endcase
            end
            // accepted request
            if (s_valid && s_ready) begin
                accepted = {s_operation, s_status_code, s_received_byte,
                            s_load_index, s_load_value};
                pending_outcomes.push_back(predict_outcome(accepted));
            end
            // accepted result against the oldest expectation
            if (m_valid && m_ready) begin
                seen = {m_send_valid, m_send_byte, m_request_start, m_clear_start,
                        m_request_stop, m_store_valid, m_store_index, m_store_value,
                        m_done_res};
                if (pending_outcomes.size() == 0) begin
                    $error("result with no request outstanding");
                    failures++;
                end else begin
                    wanted = pending_outcomes.pop_front();
                    compare_field("send_valid", wanted.send_valid, seen.send_valid);
                    compare_field("send_byte", wanted.send_byte, seen.send_byte);
                    compare_field("request_start", wanted.request_start,
                                  seen.request_start);
                    compare_field("clear_start", wanted.clear_start, seen.clear_start);
                    compare_field("request_stop", wanted.request_stop, seen.request_stop);
                    compare_field("store_valid", wanted.store_valid, seen.store_valid);
                    compare_field("store_index", wanted.store_index, seen.store_index);
                    compare_field("store_value", wanted.store_value, seen.store_value);
                    compare_field("done_res", wanted.done, seen.done);
                end
            end
        end
        outstanding = pending_outcomes.size();
    end

endmodule

### sim/tb_i2c_master_transaction_sequencer_unit.sv
// stimulus and verdict for the i2c master transaction sequencer
module tb_i2c_master_transaction_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // codes the package leaves unnamed
    localparam logic [1:0] OP_NONE        = 2'd3;
    localparam logic [1:0] MODE_UNDEFINED = 2'd3;
    localparam logic [7:0] ST_UNKNOWN     = 8'hFF;

    localparam int TARGET_REQUESTS = 900;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = i2c_mts_pkg::OP_LOAD;
    logic [7:0]  s_status_code = '0;
    logic [7:0]  s_received_byte = '0;
    logic [3:0]  s_load_index = '0;
    logic [7:0]  s_load_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_send_valid;
    logic [7:0]  m_send_byte;
    logic        m_request_start;
    logic        m_clear_start;
    logic        m_request_stop;
    logic        m_store_valid;
    logic [3:0]  m_store_index;
    logic [7:0]  m_store_value;
    logic        m_done_res;

    int   outstanding;
    int   failures;
    int   requests_sent = 0;
    logic steady = 1'b0;
    int   cur_mode;
    int   cur_tx;
    int   cur_rx;

    i2c_master_transaction_sequencer_unit uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_status_code   (s_status_code),
        .s_received_byte (s_received_byte),
        .s_load_index    (s_load_index),
        .s_load_value    (s_load_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_send_valid    (m_send_valid),
        .m_send_byte     (m_send_byte),
        .m_request_start (m_request_start),
        .m_clear_start   (m_clear_start),
        .m_request_stop  (m_request_stop),
        .m_store_valid   (m_store_valid),
        .m_store_index   (m_store_index),
        .m_store_value   (m_store_value),
        .m_done_res      (m_done_res)
    );

    i2c_mts_sequence_checker sequence_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_status_code   (s_status_code),
        .s_received_byte (s_received_byte),
        .s_load_index    (s_load_index),
        .s_load_value    (s_load_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_send_valid    (m_send_valid),
        .m_send_byte     (m_send_byte),
        .m_request_start (m_request_start),
        .m_clear_start   (m_clear_start),
        .m_request_stop  (m_request_stop),
        .m_store_valid   (m_store_valid),
        .m_store_index   (m_store_index),
        .m_store_value   (m_store_value),
        .m_done_res      (m_done_res),
        .outstanding     (outstanding),
        .failures        (failures)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side backpressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 35);
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // apb write: setup phase, access phase, then idle
    task automatic write_reg(input logic [1:0] idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input int addr, input int mode, input int tx, input int rx);
        write_reg(i2c_mts_pkg::REG_SLAVE_ADDRESS, addr);
        write_reg(i2c_mts_pkg::REG_TRANSFER_MODE, mode);
        write_reg(i2c_mts_pkg::REG_TX_COUNT, tx);
        write_reg(i2c_mts_pkg::REG_RX_COUNT, rx);
        cur_mode = mode;
        cur_tx = tx;
        cur_rx = rx;
    endtask

    // hold off requests until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic push(input logic [1:0] op, input logic [7:0] status,
                        input logic [7:0] rx_byte, input logic [3:0] idx,
                        input logic [7:0] value);
        if (!steady && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_status_code <= status;
        s_received_byte <= rx_byte;
        s_load_index <= idx;
        s_load_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op != OP_NONE) begin
            requests_sent++;
        end
    endtask

    // status event with random filler in the unused fields
    task automatic push_status(input logic [7:0] status);
        push(i2c_mts_pkg::OP_STATUS, status, 8'($urandom_range(0, 255)),
             4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 8))
            0: return i2c_mts_pkg::ST_START;
            1: return i2c_mts_pkg::ST_RESTART;
            2: return i2c_mts_pkg::ST_ADDR_W_ACK;
            3: return i2c_mts_pkg::ST_ADDR_W_NAK;
            4: return i2c_mts_pkg::ST_DATA_W_ACK;
            5: return i2c_mts_pkg::ST_ADDR_R_ACK;
            6: return i2c_mts_pkg::ST_ADDR_R_NAK;
            7: return i2c_mts_pkg::ST_DATA_R_ACK;
            default: return i2c_mts_pkg::ST_DATA_R_NAK;
        endcase
    endfunction

    function automatic int pick_value(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic push_noise();
        logic [7:0] code;
        code = ($urandom_range(99) < 70) ? pick_code() : 8'($urandom_range(0, 255));
        push(2'($urandom_range(0, 3)), code, 8'($urandom_range(0, 255)),
             4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    // read phase: data acks, up to one past the count, then at times a nak
    task automatic read_bytes();
        repeat ($urandom_range(0, cur_rx + 1)) push_status(i2c_mts_pkg::ST_DATA_R_ACK);
        if ($urandom_range(1) == 1) begin
            push_status(i2c_mts_pkg::ST_DATA_R_NAK);
        end
    endtask

    // one bus transaction as the controller would report it
    task automatic run_transaction();
        repeat ($urandom_range(0, 2)) begin
            push(i2c_mts_pkg::OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end
        push(i2c_mts_pkg::OP_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        push_status(i2c_mts_pkg::ST_START);
        if (cur_mode == i2c_mts_pkg::MODE_READ) begin
            if ($urandom_range(9) == 0) begin
                push_status(i2c_mts_pkg::ST_ADDR_R_NAK);
                return;
            end
            push_status(i2c_mts_pkg::ST_ADDR_R_ACK);
            read_bytes();
        end else begin
            if ($urandom_range(9) == 0) begin
                push_status(i2c_mts_pkg::ST_ADDR_W_NAK);
            end
            push_status(i2c_mts_pkg::ST_ADDR_W_ACK);
            repeat (cur_tx + $urandom_range(0, 1)) push_status(i2c_mts_pkg::ST_DATA_W_ACK);
            if (cur_mode == i2c_mts_pkg::MODE_WRITE_READ) begin
                push_status(i2c_mts_pkg::ST_RESTART);
                push_status(i2c_mts_pkg::ST_ADDR_R_ACK);
                read_bytes();
            end
        end
    endtask

    initial begin
        int mode;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill every transmit slot first, extremes in the first two
        configure(7'h7F, i2c_mts_pkg::MODE_WRITE_READ, 2, 16);
        for (int i = 0; i < 16; i++) begin
            push(i2c_mts_pkg::OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 4'(i), (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        end
        // ignored operation, a start, then every status code at least once
        push(OP_NONE, 8'hFF, 8'hFF, 4'hF, 8'hFF);
        push(i2c_mts_pkg::OP_START, 8'h00, 8'h00, 4'h0, 8'h00);
        push_status(i2c_mts_pkg::ST_START);
        push_status(i2c_mts_pkg::ST_ADDR_W_NAK);
        push_status(i2c_mts_pkg::ST_ADDR_W_ACK);
        push_status(i2c_mts_pkg::ST_DATA_W_ACK);
        push_status(i2c_mts_pkg::ST_DATA_W_ACK);
        push_status(i2c_mts_pkg::ST_RESTART);
        push_status(i2c_mts_pkg::ST_ADDR_R_ACK);
        push_status(ST_UNKNOWN);
        push(i2c_mts_pkg::OP_STATUS, i2c_mts_pkg::ST_DATA_R_ACK, 8'h00, 4'h0, 8'h00);
        push(i2c_mts_pkg::OP_STATUS, i2c_mts_pkg::ST_DATA_R_NAK, 8'hFF, 4'hF, 8'hFF);
        push_status(i2c_mts_pkg::ST_ADDR_R_NAK);
        drain();

        // undefined mode, reads past the buffer end and position saturation
        configure(0, MODE_UNDEFINED, 0, 0);
        push(i2c_mts_pkg::OP_START, 8'h00, 8'h00, 4'h0, 8'h00);
        repeat (34) push_status(i2c_mts_pkg::ST_ADDR_W_ACK);
        push_status(i2c_mts_pkg::ST_DATA_W_ACK);
        push_status(i2c_mts_pkg::ST_DATA_R_NAK);
        push_status(i2c_mts_pkg::ST_DATA_R_ACK);
        drain();

        // random phases, each starting from an idle block with new settings
        while (requests_sent < TARGET_REQUESTS) begin
            drain();
            steady = (requests_sent >= 300 && requests_sent < 450);
            mode = ($urandom_range(9) == 0) ? int'(MODE_UNDEFINED) : int'($urandom_range(0, 2));
            configure(pick_value(0, 127), mode, pick_value(0, 16), pick_value(0, 16));
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(99) < 80) begin
                    run_transaction();
                end else begin
                    repeat ($urandom_range(1, 6)) push_noise();
                end
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/i2c_mts_pkg.sv
rtl/i2c_mts_cfg.sv
rtl/i2c_mts_txbuf.sv
rtl/i2c_mts_ctrl.sv
rtl/i2c_master_transaction_sequencer_unit.sv
rtl/i2c_mts_checker.sv
sim/i2c_mts_sequence_checker.sv
sim/tb_i2c_master_transaction_sequencer_unit.sv
